FILE: hdl/cht_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cht_pkg: shared types and constants of the cuckoo hash table
// Request codes, field widths, register map and the sequencer control struct.
// ----------------------------------------------------------------------------
package cht_pkg;

  localparam int unsigned TableDepthDefault = 1024;
  localparam int unsigned KeyW   = 31;
  localparam int unsigned SizeW  = 11;
  localparam int unsigned KickW  = 12;
  localparam int unsigned IdxW   = 10;
  localparam int unsigned ReqW   = 2;
  localparam int unsigned AddrW  = 4;

  localparam logic [ReqW-1:0] ReqInsert = 2'd0;
  localparam logic [ReqW-1:0] ReqRead   = 2'd1;
  localparam logic [ReqW-1:0] ReqClear  = 2'd2;

  localparam logic [AddrW-1:0] AddrSizeOne = 4'h0;
  localparam logic [AddrW-1:0] AddrSizeTwo = 4'h4;
  localparam logic [AddrW-1:0] AddrKick    = 4'h8;

  typedef struct packed {
    logic [ReqW-1:0] req_type;
    logic [KeyW-1:0] key;
    logic            table_select;
    logic [IdxW-1:0] entry_index;
  } req_t;

  typedef struct packed {
    logic            status;
    logic [KeyW-1:0] dropped_key;
    logic [KickW-1:0] kicks_used;
    logic            entry_valid;
    logic [KeyW-1:0] entry_key;
  } rsp_t;

  // control from sequencer to the shared modulo unit
  typedef struct packed {
    logic            start;
    logic [KeyW-1:0] dividend;
    logic [SizeW-1:0] divisor;
  } mod_req_t;

endpackage
`default_nettype wire

FILE: hdl/cht_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cht_req_if / cht_rsp_if: valid-ready channels of the cuckoo hash table
// One word moves at an edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface cht_req_if;
  cht_pkg::req_t data;
  logic valid;
  logic ready;
  modport source (output data, output valid, input ready);
  modport sink   (input data, input valid, output ready);
endinterface

interface cht_rsp_if;
  cht_pkg::rsp_t data;
  logic valid;
  logic ready;
  modport source (output data, output valid, input ready);
  modport sink   (input data, input valid, output ready);
endinterface
`default_nettype wire

FILE: hdl/cht_mod.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cht_mod: shared restoring modulo unit
// One quotient bit a cycle; the remainder is valid when done_o is high.
// ----------------------------------------------------------------------------
module cht_mod (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire cht_pkg::mod_req_t  req_i,
  output logic                    done_o,
  output logic [cht_pkg::SizeW-1:0] rem_o
);
  import cht_pkg::*;

  localparam int unsigned CntW = $clog2(KeyW + 1);

  logic [KeyW-1:0]  shift_q, shift_d;
  logic [SizeW:0]   rem_q, rem_d;
  logic [SizeW-1:0] div_q, div_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [SizeW+1:0] trial;

  always_comb begin
    shift_d = shift_q;
    rem_d   = rem_q;
    div_d   = div_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    trial   = {rem_q, shift_q[KeyW-1]} - {2'b00, div_q};
    if (req_i.start) begin
      shift_d = req_i.dividend;
      rem_d   = '0;
      div_d   = req_i.divisor;
      cnt_d   = CntW'(KeyW);
      busy_d  = 1'b1;
    end else if (busy_q) begin
      if (trial[SizeW+1]) rem_d = {rem_q[SizeW-1:0], shift_q[KeyW-1]};
      else rem_d = trial[SizeW:0];
      shift_d = {shift_q[KeyW-2:0], 1'b0};
      cnt_d   = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
    rem_q   <= rem_d;
    div_q   <= div_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q[SizeW-1:0];
endmodule
`default_nettype wire

FILE: hdl/cuckoo_hash_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cuckoo_hash_table: two-table cuckoo hash store with kick limit
// Sequencer, two slot memories holding a valid bit and a key each, and one
// shared modulo unit.
// ----------------------------------------------------------------------------
// channel  dir  role
// req      in   request word: type, key, table select, index
// rsp      out  one result word per request
// apb      in   size and kick limit registers
// Result path: an insert runs one probe (shared modulo, memory read,
// evaluate) for the first try and one for each kick; a read does a
// memory read and evaluate; an out-of-range read or unused type goes
// straight to output. Reset and clear walk every slot with ready low.
// ready is high only in idle; a result waiting in the output register
// stalls only the next result, not the next word.
// ----------------------------------------------------------------------------
module cuckoo_hash_table #(
  parameter int unsigned TableDepth = cht_pkg::TableDepthDefault
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  cht_req_if.sink                        req,
  cht_rsp_if.source                      rsp,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [cht_pkg::AddrW-1:0] paddr,
  input  wire logic [31:0]               pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import cht_pkg::*;

  localparam int unsigned AW = $clog2(TableDepth);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StMod  = 3'd1;
  localparam logic [2:0] StRead = 3'd2;
  localparam logic [2:0] StEval = 3'd3;
  localparam logic [2:0] StOut  = 3'd4;
  localparam logic [2:0] StRdEv = 3'd5;
  localparam logic [2:0] StClr  = 3'd6;
  localparam logic [2:0] StInit = 3'd7;

  logic [SizeW-1:0] size_one_q, size_two_q;
  logic [KickW-1:0] kick_lim_q;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_one_q <= SizeW'(1024);
      size_two_q <= SizeW'(1024);
      kick_lim_q <= KickW'(256);
    end else if (wr_en) begin
      unique case (paddr)
        AddrSizeOne: size_one_q <= pwdata[SizeW-1:0];
        AddrSizeTwo: size_two_q <= pwdata[SizeW-1:0];
        AddrKick:    kick_lim_q <= pwdata[KickW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      AddrSizeOne: prdata = 32'(size_one_q);
      AddrSizeTwo: prdata = 32'(size_two_q);
      AddrKick:    prdata = 32'(kick_lim_q);
      default:     prdata = '0;
    endcase
  end

  function automatic logic [SizeW-1:0] eff_size(input logic [SizeW-1:0] v);
    logic [SizeW-1:0] r;
    r = v;
    if (v == '0) r = SizeW'(1);
    else if (32'(v) > TableDepth) r = SizeW'(TableDepth);
    return r;
  endfunction

  logic [2:0]       state_q, state_d;
  logic [KeyW-1:0]  hand_q, hand_d;
  logic             second_q, second_d;
  logic [KickW-1:0] kicks_q, kicks_d;
  logic [AW-1:0]    loc_q, loc_d;
  logic [AW-1:0]    clr_q, clr_d;
  rsp_t             out_q, out_d;
  rsp_t             rsp_q, rsp_d;
  logic             out_vld_q, out_vld_d;
  logic             is_read_q;
  mod_req_t         mreq;
  logic             mdone;
  logic [SizeW-1:0] mrem;

  logic [KeyW:0]   mem_one [TableDepth];
  logic [KeyW:0]   mem_two [TableDepth];
  logic [KeyW:0]   rd_one_q, rd_two_q;
  logic            we, wipe;
  logic [AW-1:0]   wr_addr;
  logic [KeyW:0]   wr_word;
  logic [KeyW-1:0] rd_key;
  logic            rd_vld;

  cht_mod u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mreq),
    .done_o (mdone),
    .rem_o  (mrem)
  );

  assign rd_key  = second_q ? rd_two_q[KeyW-1:0] : rd_one_q[KeyW-1:0];
  assign rd_vld  = second_q ? rd_two_q[KeyW] : rd_one_q[KeyW];
  assign wr_addr = wipe ? clr_q : loc_q;
  assign wr_word = wipe ? '0 : {1'b1, hand_q};

  always_comb begin
    state_d   = state_q;
    hand_d    = hand_q;
    second_d  = second_q;
    kicks_d   = kicks_q;
    loc_d     = loc_q;
    clr_d     = clr_q;
    out_d     = out_q;
    rsp_d     = rsp_q;
    out_vld_d = out_vld_q;
    mreq      = '0;
    we        = 1'b0;
    wipe      = 1'b0;
    if (rsp.valid && rsp.ready) out_vld_d = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (req.valid) begin
          out_d = '0;
          unique case (req.data.req_type)
            ReqInsert: begin
              hand_d        = req.data.key;
              second_d      = 1'b0;
              kicks_d       = '0;
              mreq.start    = 1'b1;
              mreq.dividend = req.data.key;
              mreq.divisor  = eff_size(size_one_q);
              state_d       = StMod;
            end
            ReqRead: begin
              second_d = req.data.table_select;
              loc_d    = AW'(req.data.entry_index);
              if (32'(req.data.entry_index) <
                  32'(eff_size(req.data.table_select ? size_two_q : size_one_q)))
                state_d = StRead;
              else state_d = StOut;
            end
            ReqClear: begin
              clr_d   = '0;
              state_d = StClr;
            end
            default: state_d = StOut;
          endcase
        end
      end
      StMod: if (mdone) begin
        loc_d   = AW'(mrem);
        state_d = StRead;
      end
      StRead: state_d = is_read_q ? StRdEv : StEval;
      StEval: begin
        if (!rd_vld) begin
          we = 1'b1;
          out_d.kicks_used = kicks_q;
          state_d = StOut;
        end else if (kicks_q >= kick_lim_q) begin
          out_d.status      = 1'b1;
          out_d.dropped_key = hand_q;
          out_d.kicks_used  = kicks_q;
          state_d = StOut;
        end else begin
          we            = 1'b1;
          hand_d        = rd_key;
          kicks_d       = kicks_q + 1'b1;
          second_d      = !second_q;
          mreq.start    = 1'b1;
          mreq.dividend = rd_key;
          mreq.divisor  = eff_size(second_q ? size_one_q : size_two_q);
          state_d       = StMod;
        end
      end
      StRdEv: begin
        out_d.entry_valid = rd_vld;
        out_d.entry_key   = rd_vld ? rd_key : '0;
        state_d = StOut;
      end
      StClr: begin
        wipe  = 1'b1;
        clr_d = clr_q + 1'b1;
        if (clr_q == AW'(TableDepth - 1)) state_d = StOut;
      end
      StInit: begin
        wipe  = 1'b1;
        clr_d = clr_q + 1'b1;
        if (clr_q == AW'(TableDepth - 1)) state_d = StIdle;
      end
      StOut: begin
        if (!out_vld_q || rsp.ready) begin
          rsp_d     = out_q;
          out_vld_d = 1'b1;
          state_d   = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StInit;
      out_vld_q <= 1'b0;
      is_read_q <= 1'b0;
      clr_q     <= '0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
      clr_q     <= clr_d;
      if (state_q == StIdle && req.valid)
        is_read_q <= (req.data.req_type == ReqRead);
    end
  end

  always_ff @(posedge clk_i) begin
    hand_q   <= hand_d;
    second_q <= second_d;
    kicks_q  <= kicks_d;
    loc_q    <= loc_d;
    out_q    <= out_d;
    rsp_q    <= rsp_d;
  end

  always_ff @(posedge clk_i) begin
    if (wipe || (we && !second_q)) mem_one[wr_addr] <= wr_word;
    rd_one_q <= mem_one[loc_q];
  end

  always_ff @(posedge clk_i) begin
    if (wipe || (we && second_q)) mem_two[wr_addr] <= wr_word;
    rd_two_q <= mem_two[loc_q];
  end

  assign req.ready = (state_q == StIdle);
  assign rsp.valid = out_vld_q;
  assign rsp.data  = rsp_q;

`ifndef ASSERT_OFF
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(rsp.data)))
    else $error("result word changed while stalled");
  a_fail_at_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp.valid && rsp.data.status) |-> (rsp.data.kicks_used == kick_lim_q))
    else $error("failure before kick limit");
  a_kick_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StEval) |-> (kicks_q <= kick_lim_q || kicks_q == '0))
    else $error("kick count past limit");
`endif
endmodule
`default_nettype wire
